// ===== src/kci_pkg.sv =====
package kci_pkg;

  // Field widths
  localparam int VAL_W     = 32;
  localparam int LEN_W     = 8;
  localparam int KEY_W     = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Clamped key: one sign bit above the key, so that an empty channel gives -1
  localparam int TKEY_W = KEY_W + 1;

  // delta (signed) times frame offset (non-negative), and its magnitude
  localparam int PROD_W     = VAL_W + TKEY_W;
  localparam int DIVIDEND_W = PROD_W - 1;
  localparam int DIV_STEPS  = DIVIDEND_W;

  localparam int DEF_MAX_SEGMENTS = 128;
  localparam int SUM_SEGMENT_CAP  = 100;
  localparam int BIG_TOTAL        = 2000;
  localparam int BIG_TOTAL_KEY    = 100;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 1'd1;

  typedef struct packed {
    logic clear;
    logic append;
    logic latch_key;
    logic look;
    logic walk;
    logic mul;
    logic absval;
    logic div_step;
    logic fix;
    logic sum;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hit_cur;
    logic hit_prev;
    logic empty;
    logic walk_more;
    logic len_zero;
  } dp_status_t;

endpackage

// ===== src/kci_ctrl.sv =====
module kci_ctrl
  import kci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ABS  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIX  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_PUT  = 4'd9;

  localparam int DCNT_W = $clog2(DIV_STEPS);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

  logic [3:0]        state_r, state_nxt;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              out_valid_r;
  logic              slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_CLEAR:  cmd.clear = 1'b1;
            CMD_APPEND: cmd.append = 1'b1;
            CMD_QUERY: begin
              cmd.latch_key = 1'b1;
              state_nxt     = S_LOOK;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (status.hit_cur || status.hit_prev || status.empty) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_WALK;
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_more) begin
          state_nxt = S_READ;
        end else if (status.len_zero) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.absval) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/kci_datapath.sv =====
module kci_datapath
  import kci_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_wdata,
  input  logic [LEN_W-1:0]        in_seg_length,
  input  logic signed [VAL_W-1:0] in_seg_delta,
  input  logic [KEY_W-1:0]        in_key,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic signed [VAL_W-1:0] out_value
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic signed [TKEY_W-1:0] T_BIG_KEY = TKEY_W'(BIG_TOTAL_KEY);
  localparam logic [KEY_W-1:0] L_BIG_TOTAL = KEY_W'(BIG_TOTAL);

  // Configuration
  logic                    fixed_mode_r;
  logic signed [VAL_W-1:0] start_value_r;

  // Segment stores, one write and one read port each
  logic [LEN_W-1:0] len_mem   [MAX_SEGMENTS];
  logic [VAL_W-1:0] delta_mem [MAX_SEGMENTS];
  logic [LEN_W-1:0]        len_q_r;
  logic signed [VAL_W-1:0] delta_q_r;

  // Channel and cursor state
  logic [CNT_W-1:0]         seg_count_r;
  logic [KEY_W-1:0]         length_sum_r;
  logic [IDX_W-1:0]         cur_idx_r;
  logic [KEY_W-1:0]         cur_total_r;
  logic [VAL_W-1:0]         cur_base_r;
  logic signed [TKEY_W-1:0] cur_key_r;
  logic signed [TKEY_W-1:0] prev_key_r;
  logic [VAL_W-1:0]         prev_res_r;
  logic [VAL_W-1:0]         roff_r;

  // Working registers
  logic [KEY_W-1:0]         key_r;
  logic [KEY_W-1:0]         diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DIVIDEND_W-1:0]    quo_r, quo_nxt;
  logic [LEN_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r;
  logic [VAL_W-1:0]         res_r;
  logic [VAL_W-1:0]         out_value_r;

  logic signed [TKEY_W-1:0] key_ext, lsum_ext, t_key, walk_diff, len_ext, diff_s;
  logic [VAL_W-1:0]         app_delta, base_eff, quo_low;
  logic [IDX_W-1:0]         idx_eff;
  logic                     rewind, can_append;
  logic [LEN_W:0]           trial;
  logic signed [PROD_W-1:0] prod_neg;

  assign key_ext  = TKEY_W'({1'b0, key_r});
  assign lsum_ext = TKEY_W'({1'b0, length_sum_r});

  // Clamp the key to the channel length, then to the short range of long channels
  always_comb begin
    t_key = key_ext;
    if (key_ext >= lsum_ext) begin
      t_key = lsum_ext - TKEY_W'(1);
    end
    if (length_sum_r > L_BIG_TOTAL && t_key > T_BIG_KEY) begin
      t_key = T_BIG_KEY;
    end
  end

  assign rewind   = (t_key < cur_key_r);
  assign idx_eff  = rewind ? '0 : cur_idx_r;
  assign base_eff = rewind ? start_value_r : cur_base_r;

  assign len_ext   = TKEY_W'({1'b0, len_q_r});
  assign walk_diff = cur_key_r - TKEY_W'({1'b0, cur_total_r});
  assign diff_s    = TKEY_W'({1'b0, diff_r});

  assign status.hit_cur   = (key_ext == cur_key_r);
  assign status.hit_prev  = (key_ext == prev_key_r);
  assign status.empty     = t_key[TKEY_W-1] || (seg_count_r == '0) ||
                            (CNT_W'(idx_eff) >= seg_count_r);
  assign status.walk_more = (walk_diff > len_ext) &&
                            ((CNT_W'(cur_idx_r) + CNT_W'(1)) < seg_count_r);
  assign status.len_zero  = (len_q_r == '0);

  assign can_append = (seg_count_r < CNT_W'(MAX_SEGMENTS));
  assign app_delta  = fixed_mode_r ? {{(VAL_W-16){in_seg_delta[15]}}, in_seg_delta[15:0]}
                                   : in_seg_delta;

  // One restoring step of the magnitude division
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    if (trial >= {1'b0, len_q_r}) begin
      rem_nxt = LEN_W'(trial - {1'b0, len_q_r});
      quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[LEN_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
    end
  end

  assign prod_neg = -prod_r;
  assign quo_low  = quo_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r  <= 1'b1;
      start_value_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIXED_MODE:  fixed_mode_r <= cfg_wdata[0];
        CFG_START_VALUE: start_value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && can_append) begin
      len_mem[seg_count_r[IDX_W-1:0]]   <= in_seg_length;
      delta_mem[seg_count_r[IDX_W-1:0]] <= app_delta;
    end
  end

  always_ff @(posedge clk) begin
    len_q_r   <= len_mem[cur_idx_r];
    delta_q_r <= delta_mem[cur_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r  <= '0;
      length_sum_r <= '0;
      cur_idx_r    <= '0;
      cur_total_r  <= '0;
      cur_base_r   <= '0;
      cur_key_r    <= '1;
      prev_key_r   <= '1;
      prev_res_r   <= '0;
      roff_r       <= '0;
    end else if (cmd.clear) begin
      seg_count_r  <= '0;
      length_sum_r <= '0;
      cur_idx_r    <= '0;
      cur_total_r  <= '0;
      cur_base_r   <= start_value_r;
      cur_key_r    <= '1;
      prev_key_r   <= '1;
      prev_res_r   <= '0;
      roff_r       <= '0;
    end else begin
      if (cmd.append && can_append) begin
        seg_count_r <= seg_count_r + CNT_W'(1);
        if (32'(seg_count_r) < SUM_SEGMENT_CAP) begin
          length_sum_r <= length_sum_r + KEY_W'(in_seg_length);
        end
      end
      if (cmd.look && !status.hit_cur && !status.hit_prev) begin
        prev_res_r <= cur_base_r + roff_r;
        prev_key_r <= cur_key_r;
        cur_key_r  <= t_key;
        if (rewind) begin
          cur_idx_r   <= '0;
          cur_total_r <= '0;
          cur_base_r  <= start_value_r;
        end
        if (status.empty) begin
          roff_r <= '0;
        end
      end
      if (cmd.walk) begin
        if (status.walk_more) begin
          cur_total_r <= cur_total_r + KEY_W'(len_q_r);
          cur_base_r  <= cur_base_r + delta_q_r;
          cur_idx_r   <= cur_idx_r + IDX_W'(1);
        end else if (status.len_zero) begin
          roff_r <= '0;
        end
      end
      if (cmd.fix) begin
        roff_r <= neg_r ? -quo_low : quo_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_key) begin
      key_r <= in_key;
    end
    if (cmd.look) begin
      if (status.hit_cur) begin
        res_r <= cur_base_r + roff_r;
      end else if (status.hit_prev) begin
        res_r <= prev_res_r;
      end else begin
        res_r <= base_eff;
      end
    end
    if (cmd.walk) begin
      diff_r <= walk_diff[KEY_W-1:0];
      res_r  <= cur_base_r;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(delta_q_r) * PROD_W'(diff_s);
    end
    if (cmd.absval) begin
      neg_r <= prod_r[PROD_W-1];
      quo_r <= prod_r[PROD_W-1] ? prod_neg[DIVIDEND_W-1:0] : prod_r[DIVIDEND_W-1:0];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.sum) begin
      res_r <= cur_base_r + roff_r;
    end
    if (cmd.out_load) begin
      out_value_r <= res_r;
    end
  end

  assign out_value = out_value_r;

endmodule

// ===== src/keyframe_curve_interpolator.sv =====
// Piecewise linear keyframe curve, one animation channel. Append items load
// segments (frame length, value delta) into on-chip stores of MAX_SEGMENTS
// entries; clear items empty the channel; query items return the Q19.12 value
// at a key frame, one result item each. Appends and clears are done in the
// idle state. A query that hits one of the two cached keys, or finds the
// channel empty, goes straight to the output. Other queries walk the cursor
// over the skipped segments, each step waiting on the registered read of the
// segment stores, then multiply and divide bit-serially by the segment length
// unless it is zero. The block takes one item at a time; a finished result
// waits in the output register, so a new item is taken while it is stalled.
module keyframe_curve_interpolator
  import kci_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_wdata,
  // command items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [LEN_W-1:0]        in_seg_length,
  input  logic signed [VAL_W-1:0] in_seg_delta,
  input  logic [KEY_W-1:0]        in_key,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer: accepts items, steps the cursor walk and the divide, hands off results
  kci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Stores, cursor, key caches, multiplier, divider and output register
  kci_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_seg_length (in_seg_length),
    .in_seg_delta  (in_seg_delta),
    .in_key        (in_key),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .out_value     (out_value)
  );

`ifndef SYNTHESIS
  // A query keeps the input side held off while it is evaluated
  a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == CMD_QUERY) |=> in_stall)
    else $error("input taken while a query is in progress");

  // Datapath steps are exclusive
  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.look, dp_cmd.walk, dp_cmd.mul, dp_cmd.absval, dp_cmd.div_step,
              dp_cmd.fix, dp_cmd.sum, dp_cmd.out_load}))
    else $error("more than one datapath step in one cycle");

  // A result is loaded only into a free or departing output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || !out_stall))
    else $error("stalled result overwritten");
`endif

endmodule
